### design/skfa_pkg.sv
// ----------------------------------------------------------------------------
// skfa_pkg
// Shared types and constants of the sensor Kalman anomaly filter.
// ----------------------------------------------------------------------------
package skfa_pkg;

  localparam int DEFAULT_RING_DEPTH = 256;

  localparam int DIV_NUM_W = 35;
  localparam int DIV_DEN_W = 20;
  localparam int DIV_CNT_W = 6;

  localparam int WSUM_W = 25;

  localparam logic [8:0]  RST_WINDOW_LENGTH   = 9'd256;
  localparam logic [7:0]  RST_SIGMA_THRESHOLD = 8'd40;
  localparam logic [15:0] RST_PROCESS_NOISE   = 16'd655;
  localparam logic [15:0] RST_MEASURE_NOISE   = 16'd6554;
  localparam logic [17:0] RST_COVARIANCE      = 18'd65536;

  typedef enum logic [1:0] {
    CFG_WINDOW_LENGTH   = 2'd0,
    CFG_SIGMA_THRESHOLD = 2'd1,
    CFG_PROCESS_NOISE   = 2'd2,
    CFG_MEASURE_NOISE   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [8:0]  window_length;
    logic [7:0]  sigma_threshold;
    logic [15:0] process_noise;
    logic [15:0] measure_noise;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [30:0]        square;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 valid;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

### design/skfa_divider.sv
// ----------------------------------------------------------------------------
// skfa_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module skfa_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  skfa_pkg::div_req_t  req,
  output skfa_pkg::div_rsp_t  rsp
);
  import skfa_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] den_r;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DIV_NUM_W);
      rem_r  <= '0;
      quo_r  <= req.num;
      den_r  <= req.den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.valid = done_r;
  assign rsp.quo   = quo_r;

endmodule

### design/skfa_front.sv
// ----------------------------------------------------------------------------
// skfa_front
// Accepts samples, squares them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module skfa_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_sample,
  output logic                item_valid,
  output skfa_pkg::item_t     item,
  input  logic                item_pop
);
  import skfa_pkg::*;

  item_t       entry_r [2];
  logic [1:0]  count_r;
  logic        wp_r;
  logic        rp_r;
  logic        push;
  logic        pop;
  logic signed [31:0] square_full;

  assign square_full = in_sample * in_sample;
  assign in_stall    = count_r == 2'd2;
  assign push        = in_valid && !in_stall;
  assign item_valid  = count_r != 2'd0;
  assign pop         = item_pop && item_valid;
  assign item        = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      if (push) begin
        entry_r[wp_r].sample <= in_sample;
        entry_r[wp_r].square <= square_full[30:0];
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### design/skfa_back.sv
// ----------------------------------------------------------------------------
// skfa_back
// Sample ring, running totals, window sum, anomaly test and Kalman update.
// ----------------------------------------------------------------------------
module skfa_back #(
  parameter int RING_DEPTH = skfa_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  skfa_pkg::cfg_t      cfg,
  input  logic                item_valid,
  input  skfa_pkg::item_t     item,
  output logic                item_pop,
  output skfa_pkg::div_req_t  div_req,
  input  skfa_pkg::div_rsp_t  div_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_filtered_value,
  output logic signed [15:0]  out_window_mean,
  output logic                out_anomaly,
  output logic [8:0]          out_held_count
);
  import skfa_pkg::*;

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int FW     = $clog2(RING_DEPTH + 1);
  localparam int TOT_W  = 16 + AW;
  localparam int SQ_W   = 32 + AW;
  localparam int PA_W   = FW + SQ_W;
  localparam int NS_W   = FW + TOT_W + 1;
  localparam int LHS_W  = 2 * NS_W + 8;
  localparam int RHS_W  = 16 + PA_W;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int CW     = (FW > 9) ? FW : 9;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INGEST, ST_WIN_RD, ST_WIN_ACC, ST_AN_MUL, ST_AN_SUB, ST_AN_SQR,
    ST_AN_CMP, ST_K_WAIT, ST_K_MUL, ST_K_UPD, ST_M_WAIT, ST_OUT
  } state_t;

  state_t state_r;

  logic [15:0]          ring_mem [RING_DEPTH];
  logic [15:0]          rd_data_r;
  logic                 mem_re;
  logic [AW-1:0]        mem_ra;

  logic signed [15:0]   s_r;
  logic [30:0]          sq_in_r;
  logic [AW-1:0]        slot_r;
  logic [AW-1:0]        rp_r;
  logic [FW-1:0]        fill_r;
  logic signed [TOT_W-1:0] rt_r;
  logic [SQ_W-1:0]      sq_r;
  logic [17:0]          cov_r;
  logic signed [31:0]   x_r;
  logic [18:0]          pp_r;
  logic                 den_zero_r;
  logic [8:0]           w_r;
  logic [8:0]           cnt_r;
  logic signed [WSUM_W-1:0] wsum_r;

  logic [PA_W-1:0]      pa_r;
  logic [2*TOT_W-1:0]   ssq_r;
  logic signed [NS_W-1:0] ns_r;
  logic [15:0]          t_r;
  logic [PA_W-1:0]      d_r;
  logic [NS_W-1:0]      an_r;
  logic [2*NS_W-1:0]    lhs_r;
  logic [RHS_W-1:0]     rhs_r;
  logic                 anom_r;

  logic [16:0]          k_r;
  logic signed [50:0]   prod_r;
  logic [35:0]          pnew_r;
  logic signed [15:0]   mean_r;

  logic                 out_valid_r;
  logic signed [15:0]   out_fv_r;
  logic signed [15:0]   out_wm_r;
  logic                 out_an_r;
  logic [8:0]           out_hc_r;

  logic                 full;
  logic signed [15:0]   old;
  logic signed [31:0]   old_sq;
  logic [FW-1:0]        fill_nxt;
  logic [8:0]           wl_eff;
  logic [8:0]           w_nxt;
  logic [18:0]          pp_nxt;
  logic [19:0]          den_nxt;
  logic                 wneg;
  logic [WSUM_W-1:0]    wabs;
  logic [TOT_W-1:0]     sabs;
  logic signed [NS_W-1:0] num_d;
  logic signed [32:0]   kdiff;
  logic signed [51:0]   rnd;
  logic [16:0]          omk;
  logic [15:0]          q16;

  assign full     = fill_r == FW'(RING_DEPTH);
  assign old      = full ? $signed(rd_data_r) : 16'sd0;
  assign old_sq   = old * old;
  assign fill_nxt = full ? fill_r : fill_r + 1'b1;
  assign wl_eff   = (cfg.window_length == 9'd0) ? 9'd1 : cfg.window_length;
  assign w_nxt    = (CW'(wl_eff) > CW'(fill_nxt)) ? 9'(fill_nxt) : wl_eff;
  assign pp_nxt   = 19'(cov_r) + 19'(cfg.process_noise);
  assign den_nxt  = 20'(pp_nxt) + 20'(cfg.measure_noise);
  assign wneg     = wsum_r[WSUM_W-1];
  assign wabs     = wneg ? WSUM_W'(-wsum_r) : WSUM_W'(wsum_r);
  assign sabs     = rt_r[TOT_W-1] ? TOT_W'(-rt_r) : TOT_W'(rt_r);
  assign num_d    = ns_r - NS_W'(rt_r);
  assign kdiff    = 33'($signed({s_r, 16'h0000})) - 33'(x_r);
  assign rnd      = 52'(prod_r) + 52'sd32768;
  assign omk      = 17'(18'd65536 - 18'(k_r));
  assign q16      = div_rsp.quo[15:0];

  assign item_pop = (state_r == ST_IDLE) && item_valid;
  assign mem_re   = item_pop || (state_r == ST_WIN_RD && cnt_r != 9'd0);
  assign mem_ra   = (state_r == ST_IDLE) ? slot_r : rp_r;

  assign div_req.start = (state_r == ST_INGEST) || (state_r == ST_K_UPD);
  assign div_req.num   = (state_r == ST_INGEST) ? {pp_nxt, 16'h0000} : DIV_NUM_W'(wabs);
  assign div_req.den   = (state_r == ST_INGEST) ? den_nxt : DIV_DEN_W'(w_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_INGEST) begin
      ring_mem[slot_r] <= s_r;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      rt_r        <= '0;
      sq_r        <= '0;
      cov_r       <= RST_COVARIANCE;
      x_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (item_valid) begin
            s_r     <= item.sample;
            sq_in_r <= item.square;
            state_r <= ST_INGEST;
          end
        end
        ST_INGEST: begin
          rt_r       <= rt_r + TOT_W'(s_r) - TOT_W'(old);
          sq_r       <= sq_r + SQ_W'(sq_in_r) - SQ_W'(old_sq[30:0]);
          fill_r     <= fill_nxt;
          slot_r     <= (slot_r == AW'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;
          rp_r       <= (slot_r == '0) ? AW'(RING_DEPTH - 1) : slot_r - 1'b1;
          w_r        <= w_nxt;
          cnt_r      <= w_nxt - 9'd1;
          wsum_r     <= WSUM_W'(s_r);
          pp_r       <= pp_nxt;
          den_zero_r <= den_nxt == 20'd0;
          state_r    <= ST_WIN_RD;
        end
        ST_WIN_RD: begin
          if (cnt_r == 9'd0) begin
            state_r <= ST_AN_MUL;
          end else begin
            rp_r    <= (rp_r == '0) ? AW'(RING_DEPTH - 1) : rp_r - 1'b1;
            cnt_r   <= cnt_r - 9'd1;
            state_r <= ST_WIN_ACC;
          end
        end
        ST_WIN_ACC: begin
          wsum_r  <= wsum_r + WSUM_W'($signed(rd_data_r));
          state_r <= ST_WIN_RD;
        end
        ST_AN_MUL: begin
          pa_r    <= PA_W'(fill_r) * PA_W'(sq_r);
          ssq_r   <= (2*TOT_W)'(sabs) * (2*TOT_W)'(sabs);
          ns_r    <= NS_W'($signed({1'b0, fill_r}) * s_r);
          t_r     <= cfg.sigma_threshold * cfg.sigma_threshold;
          state_r <= ST_AN_SUB;
        end
        ST_AN_SUB: begin
          d_r     <= pa_r - PA_W'(ssq_r);
          an_r    <= num_d[NS_W-1] ? NS_W'(-num_d) : NS_W'(num_d);
          state_r <= ST_AN_SQR;
        end
        ST_AN_SQR: begin
          lhs_r   <= (2*NS_W)'(an_r) * (2*NS_W)'(an_r);
          rhs_r   <= RHS_W'(t_r) * RHS_W'(d_r);
          state_r <= ST_AN_CMP;
        end
        ST_AN_CMP: begin
          anom_r  <= (CW'(fill_r) >= CW'(4)) && (d_r != '0) &&
                     (CMP_W'({lhs_r, 8'h00}) > CMP_W'(rhs_r));
          state_r <= ST_K_WAIT;
        end
        ST_K_WAIT: begin
          if (div_rsp.valid) begin
            k_r     <= den_zero_r ? 17'd0 : div_rsp.quo[16:0];
            state_r <= ST_K_MUL;
          end
        end
        ST_K_MUL: begin
          prod_r  <= $signed({1'b0, k_r}) * kdiff;
          pnew_r  <= 36'(omk) * 36'(pp_r);
          state_r <= ST_K_UPD;
        end
        ST_K_UPD: begin
          x_r     <= x_r + 32'(rnd >>> 16);
          cov_r   <= pnew_r[33:16];
          state_r <= ST_M_WAIT;
        end
        ST_M_WAIT: begin
          if (div_rsp.valid) begin
            mean_r  <= wneg ? $signed(-q16) : $signed(q16);
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_fv_r    <= x_r[31:16];
            out_wm_r    <= mean_r;
            out_an_r    <= anom_r;
            out_hc_r    <= 9'(fill_r);
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_fv_r;
  assign out_window_mean    = out_wm_r;
  assign out_anomaly        = out_an_r;
  assign out_held_count     = out_hc_r;

endmodule

### design/sensor_kalman_anomaly_filter_core.sv
// ----------------------------------------------------------------------------
// sensor_kalman_anomaly_filter_core
// Kalman smoothing, window mean and outlier flag for a stream of samples.
// ----------------------------------------------------------------------------
// Per sample, the gain division and then the mean division run in turn on the shared
// divider, and the window sum is read from the ring one entry at a time.
// A new sample is taken from the input queue only once the last result is
// registered at the output; two samples queue at the input meanwhile.
// Reset clears control state, totals and the filter; ring contents are not cleared.
module sensor_kalman_anomaly_filter_core #(
  parameter int RING_DEPTH = skfa_pkg::DEFAULT_RING_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_filtered_value,
  output logic signed [15:0] out_window_mean,
  output logic               out_anomaly,
  output logic [8:0]         out_held_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import skfa_pkg::*;

  cfg_t     cfg_r;
  item_t    item;
  logic     item_valid;
  logic     item_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length   <= RST_WINDOW_LENGTH;
      cfg_r.sigma_threshold <= RST_SIGMA_THRESHOLD;
      cfg_r.process_noise   <= RST_PROCESS_NOISE;
      cfg_r.measure_noise   <= RST_MEASURE_NOISE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_WINDOW_LENGTH:   cfg_r.window_length   <= cfg_data[8:0];
        CFG_SIGMA_THRESHOLD: cfg_r.sigma_threshold <= cfg_data[7:0];
        CFG_PROCESS_NOISE:   cfg_r.process_noise   <= cfg_data;
        CFG_MEASURE_NOISE:   cfg_r.measure_noise   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  skfa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  skfa_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  skfa_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .item_valid         (item_valid),
    .item               (item),
    .item_pop           (item_pop),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_value (out_filtered_value),
    .out_window_mean    (out_window_mean),
    .out_anomaly        (out_anomaly),
    .out_held_count     (out_held_count)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sensor Kalman anomaly filter core. A predictor
// tracks the sample ring, the running totals and the Kalman state. It checks
// every result beat field by field, over several register settings, under
// random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import skfa_pkg::*;

  localparam int DEPTH = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] filt;
    logic signed [15:0] mean;
    logic               anom;
    logic [8:0]         held;
  } filter_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_filtered_value;
  logic signed [15:0] out_window_mean;
  logic out_anomaly;
  logic [8:0] out_held_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sensor_kalman_anomaly_filter_core #(.RING_DEPTH(DEPTH)) u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [8:0]  win_len;
  logic [7:0]  sig_thr;
  logic [15:0] q_noise;
  logic [15:0] r_noise;
  logic signed [15:0] ring [DEPTH];
  int unsigned slot;
  int unsigned fill;
  longint ring_sum;
  longint unsigned ring_sq_sum;
  longint unsigned cov;
  longint est;

  filter_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int anomalies_seen = 0;
  bit idle_enable = 1'b1;
  bit hold_output = 1'b0;
  int quiet_cycles = 0;

  function automatic longint floor_q16(longint v);
    return v >>> 16;
  endfunction

  function automatic void reset_predictor();
    win_len = RST_WINDOW_LENGTH;
    sig_thr = RST_SIGMA_THRESHOLD;
    q_noise = RST_PROCESS_NOISE;
    r_noise = RST_MEASURE_NOISE;
    slot = 0;
    fill = 0;
    ring_sum = 0;
    ring_sq_sum = 0;
    cov = RST_COVARIANCE;
    est = 0;
  endfunction

  function automatic filter_result_t predict_filter(logic signed [15:0] s);
    filter_result_t r;
    longint unsigned pp, den, k;
    longint prod, wsum, n_l;
    int unsigned w;
    logic signed [127:0] num, lhs, rhs, d;
    if (fill >= DEPTH) begin
      ring_sum -= ring[slot];
      ring_sq_sum -= longint'(ring[slot]) * longint'(ring[slot]);
    end
    ring[slot] = s;
    ring_sum += s;
    ring_sq_sum += longint'(s) * longint'(s);
    slot = (slot + 1) % DEPTH;
    if (fill < DEPTH) fill++;
    pp = cov + q_noise;
    den = pp + r_noise;
    k = (den != 0) ? (pp << 16) / den : 0;
    prod = longint'(k) * (longint'(s) * 65536 - est);
    est += floor_q16(prod + 32768);
    cov = (((65536 - k) * pp) >> 16) & 18'h3FFFF;
    w = (win_len == 0) ? 1 : win_len;
    if (w > fill) w = fill;
    wsum = 0;
    for (int i = 0; i < w; i++) wsum += ring[(slot + 2 * DEPTH - 1 - i) % DEPTH];
    n_l = fill;
    r.filt = 16'(floor_q16(est));
    r.mean = 16'(wsum / longint'(w));
    r.held = 9'(fill);
    r.anom = 1'b0;
    d = 128'(n_l) * 128'(ring_sq_sum) - 128'(ring_sum) * 128'(ring_sum);
    if (fill >= 4 && d != 0) begin
      num = 128'(n_l * s - ring_sum);
      lhs = 256 * num * num;
      rhs = 128'(sig_thr) * 128'(sig_thr) * d;
      r.anom = lhs > rhs;
    end
    return r;
  endfunction

  task automatic write_register(cfg_index_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW_LENGTH:   win_len = value[8:0];
      CFG_SIGMA_THRESHOLD: sig_thr = value[7:0];
      CFG_PROCESS_NOISE:   q_noise = value;
      CFG_MEASURE_NOISE:   r_noise = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic configure(logic [8:0] wl, logic [7:0] st, logic [15:0] q, logic [15:0] r);
    wait_drained();
    write_register(CFG_WINDOW_LENGTH, 16'(wl));
    write_register(CFG_SIGMA_THRESHOLD, 16'(st));
    write_register(CFG_PROCESS_NOISE, q);
    write_register(CFG_MEASURE_NOISE, r);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(logic signed [15:0] s);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_filter(s));
  endtask

  function automatic logic signed [15:0] random_sample(logic signed [15:0] centre);
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return centre + 16'(int'($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] pattern [12] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0100,
      16'sh0100, 16'sh0100, 16'sh0100, 16'sh7FFF, 16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh0001};
    foreach (pattern[i]) send_sample(pattern[i]);
    configure(9'd0, 8'd0, 16'd0, 16'd1);
    repeat (6) send_sample(16'sh0200);
    send_sample(16'sh0201);
    configure(9'd300, 8'd255, 16'hFFFF, 16'hFFFF);
    repeat (6) send_sample(random_sample(16'sh0000));
  endtask

  task automatic test_random_phase(int count);
    logic signed [15:0] centre;
    centre = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 40) == 0) centre = 16'($urandom);
      send_sample(random_sample(centre));
    end
  endtask

  task automatic test_back_pressure();
    hold_output = 1'b1;
    for (int i = 0; i < 6; i++) send_sample(random_sample(16'sh0400));
    wait_drained();
  endtask

  task automatic test_no_idling();
    idle_enable = 1'b0;
    test_random_phase(150);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_output) begin
        out_stall <= 1'b1;
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= 1500) begin
          hold_output = 1'b0;
          quiet_cycles = 0;
        end
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
      end else if (!idle_enable || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    filter_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, filtered %0d", $time, out_filtered_value);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_anomaly) anomalies_seen++;
        if (out_filtered_value !== exp_r.filt) begin
          errors++;
          $display("%0t: filtered_value expected %0d actual %0d", $time, exp_r.filt,
                   out_filtered_value);
        end
        if (out_window_mean !== exp_r.mean) begin
          errors++;
          $display("%0t: window_mean expected %0d actual %0d", $time, exp_r.mean,
                   out_window_mean);
        end
        if (out_anomaly !== exp_r.anom) begin
          errors++;
          $display("%0t: anomaly expected %0b actual %0b", $time, exp_r.anom, out_anomaly);
        end
        if (out_held_count !== exp_r.held) begin
          errors++;
          $display("%0t: held_count expected %0d actual %0d", $time, exp_r.held,
                   out_held_count);
        end
      end
    end
  end

  int idle_count = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    configure(9'd1, 8'd16, 16'd0, 16'd65535);
    test_random_phase(200);
    configure(9'd256, 8'd40, 16'd655, 16'd6554);
    test_random_phase(400);
    test_back_pressure();
    configure(9'd17, 8'd1, 16'd1000, 16'd1);
    test_random_phase(200);
    test_no_idling();
    wait_drained();
    $display("Checked %0d result beats, %0d flagged as anomalies, over six register settings",
             results_seen, anomalies_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sensor_kalman_anomaly_filter_core.f
design/skfa_pkg.sv
design/skfa_divider.sv
design/skfa_front.sv
design/skfa_back.sv
design/sensor_kalman_anomaly_filter_core.sv
bench/tb.sv
